// ===== rtl/core/wbs_pkg.sv =====
// shared types and constants of the weighted background subtractor
package wbs_pkg;

    localparam int LUMA_W      = 8;
    localparam int HIST_W      = 2 * LUMA_W;
    localparam int WEIGHT_W    = 16;
    localparam int PROD_W      = WEIGHT_W + LUMA_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int PAIR_W      = 16;
    localparam int WORD_W      = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_LEARN_MODE      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_CURRENT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_PREVIOUS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_OLDER    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_THRESHOLD = 3'd4;

    // register reset values (weights are q0.16 for 0.1, 0.2 and 0.7)
    localparam logic [WEIGHT_W-1:0] WEIGHT_CURRENT_RST  = 16'd6554;
    localparam logic [WEIGHT_W-1:0] WEIGHT_PREVIOUS_RST = 16'd13107;
    localparam logic [WEIGHT_W-1:0] WEIGHT_OLDER_RST    = 16'd45875;
    localparam logic [LUMA_W-1:0]   MATCH_THRESHOLD_RST = 8'd15;

    // mask values
    localparam logic [LUMA_W-1:0] MASK_BACKGROUND = 8'd0;
    localparam logic [LUMA_W-1:0] MASK_FOREGROUND = 8'd255;
    localparam logic [LUMA_W-1:0] LUMA_MAX        = 8'd255;

    // yuyv luma bit offsets
    localparam int Y1_LSB = 0;
    localparam int Y2_LSB = 16;

    typedef struct packed {
        logic                learn_mode;
        logic [WEIGHT_W-1:0] weight_current;
        logic [WEIGHT_W-1:0] weight_previous;
        logic [WEIGHT_W-1:0] weight_older;
        logic [LUMA_W-1:0]   match_threshold;
    } cfg_t;

endpackage

// ===== rtl/core/wbs_if.sv =====
// handshake interfaces of the weighted background subtractor

// pixel pair words in
interface wbs_pair_if;
    logic                          valid;
    logic                          ready;
    logic [wbs_pkg::PAIR_W-1:0]    pair_index;
    logic [wbs_pkg::WORD_W-1:0]    yuyv_word;

    modport source (output valid, output pair_index, output yuyv_word, input ready);
    modport sink   (input valid, input pair_index, input yuyv_word, output ready);
endinterface

// mask words out
interface wbs_result_if;
    logic                          valid;
    logic                          ready;
    logic [wbs_pkg::LUMA_W-1:0]    out_pixel_first;
    logic [wbs_pkg::LUMA_W-1:0]    out_pixel_second;

    modport source (output valid, output out_pixel_first, output out_pixel_second,
                    input ready);
    modport sink   (input valid, input out_pixel_first, input out_pixel_second,
                    output ready);
endinterface

// configuration writes
interface wbs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [wbs_pkg::CFG_INDEX_W-1:0]   index;
    logic [wbs_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/weighted_background_subtract.sv =====
// top level of the weighted background subtractor
// Takes one YUYV word per clock while the output word is taken and returns one mask
// word per word taken; the mask word is valid behind three register stages:
// a history read stage, a product stage and the output register. The two luma
// samples of a word run in two lanes side by side, each
// with its own history bank of ceil(FRAME_PIXELS/2) x 16 bits (one read and one
// write per cycle); the output register merges both lanes into one word. A read
// that meets the write of the word just before it is forwarded. History holds
// nothing meaningful until a learn frame has written it; there is no clearing
// pass after reset. Pixels at or past FRAME_PIXELS read zero history and are not
// stored. The pipeline stalls as a whole while the output word is not taken.
module weighted_background_subtract #(
    parameter int FRAME_PIXELS = 76800
) (
    input  logic           clk,
    input  logic           rst_n,
    wbs_pair_if.sink       pixel,
    wbs_result_if.source   result,
    wbs_cfg_if.sink        cfg
);

    localparam int PAIRS_FULL   = (FRAME_PIXELS + 1) / 2;
    localparam int PAIR_SPAN    = 1 << wbs_pkg::PAIR_W;
    localparam int ROWS         = (PAIRS_FULL < PAIR_SPAN) ? PAIRS_FULL : PAIR_SPAN;
    localparam int ADDR_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FIRST_LIMIT  = (FRAME_PIXELS + 1) / 2;
    localparam int SECOND_LIMIT = FRAME_PIXELS / 2;
    localparam int L            = wbs_pkg::LUMA_W;

    wbs_pkg::cfg_t regs;

    logic advance;
    logic accept;

    logic                       s1_valid_reg;
    logic [wbs_pkg::PAIR_W-1:0] s1_pair_reg;
    logic [L-1:0]               s1_luma_first_reg;
    logic [L-1:0]               s1_luma_second_reg;
    logic                       s1_in_first_reg;
    logic                       s1_in_second_reg;
    logic                       s2_valid_reg;
    logic                       res_valid_reg;
    logic [L-1:0]               res_first_reg;
    logic [L-1:0]               res_second_reg;

    logic                       fwd_valid_reg;
    logic [wbs_pkg::PAIR_W-1:0] fwd_pair_reg;
    logic [wbs_pkg::HIST_W-1:0] fwd_first_reg;
    logic [wbs_pkg::HIST_W-1:0] fwd_second_reg;
    logic                       fwd_hit;

    logic [wbs_pkg::HIST_W-1:0] rd_first;
    logic [wbs_pkg::HIST_W-1:0] rd_second;
    logic [wbs_pkg::HIST_W-1:0] hist_first;
    logic [wbs_pkg::HIST_W-1:0] hist_second;
    logic [wbs_pkg::HIST_W-1:0] new_first;
    logic [wbs_pkg::HIST_W-1:0] new_second;
    logic [L-1:0]               pix_first;
    logic [L-1:0]               pix_second;
    logic                       s1_move;

    // whole-pipeline stall on a held output word
    assign advance     = !res_valid_reg || result.ready;
    assign accept      = pixel.valid && advance;
    assign pixel.ready = advance;
    assign s1_move     = advance && s1_valid_reg;

    wbs_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= pixel.valid;
            s2_valid_reg  <= s1_valid_reg;
            res_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pair_reg        <= pixel.pair_index;
            s1_luma_first_reg  <= pixel.yuyv_word[wbs_pkg::Y1_LSB +: L];
            s1_luma_second_reg <= pixel.yuyv_word[wbs_pkg::Y2_LSB +: L];
            s1_in_first_reg    <= 32'(pixel.pair_index) < 32'(FIRST_LIMIT);
            s1_in_second_reg   <= 32'(pixel.pair_index) < 32'(SECOND_LIMIT);
        end
    end

    // last history write, for a read issued on the same edge
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            fwd_pair_reg   <= s1_pair_reg;
            fwd_first_reg  <= new_first;
            fwd_second_reg <= new_second;
        end
    end

    assign fwd_hit     = fwd_valid_reg && (fwd_pair_reg == s1_pair_reg);
    assign hist_first  = fwd_hit ? fwd_first_reg : rd_first;
    assign hist_second = fwd_hit ? fwd_second_reg : rd_second;

    wbs_history #(
        .DEPTH  (ROWS),
        .ADDR_W (ADDR_W)
    ) u_hist_first (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (pixel.pair_index[ADDR_W-1:0]),
        .rd_data (rd_first),
        .wr_en   (s1_move && s1_in_first_reg),
        .wr_addr (s1_pair_reg[ADDR_W-1:0]),
        .wr_data (new_first)
    );

    wbs_history #(
        .DEPTH  (ROWS),
        .ADDR_W (ADDR_W)
    ) u_hist_second (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (pixel.pair_index[ADDR_W-1:0]),
        .rd_data (rd_second),
        .wr_en   (s1_move && s1_in_second_reg),
        .wr_addr (s1_pair_reg[ADDR_W-1:0]),
        .wr_data (new_second)
    );

    wbs_lane u_lane_first (
        .clk      (clk),
        .en       (s1_move),
        .regs     (regs),
        .in_frame (s1_in_first_reg),
        .luma     (s1_luma_first_reg),
        .hist     (hist_first),
        .hist_new (new_first),
        .pixel    (pix_first)
    );

    wbs_lane u_lane_second (
        .clk      (clk),
        .en       (s1_move),
        .regs     (regs),
        .in_frame (s1_in_second_reg),
        .luma     (s1_luma_second_reg),
        .hist     (hist_second),
        .hist_new (new_second),
        .pixel    (pix_second)
    );

    // merge both lanes into the output word
    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            res_first_reg  <= pix_first;
            res_second_reg <= pix_second;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.out_pixel_first  = res_first_reg;
    assign result.out_pixel_second = res_second_reg;

endmodule

// ===== rtl/core/wbs_cfg_regs.sv =====
// configuration register file
module wbs_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    wbs_cfg_if.sink          cfg,
    output wbs_pkg::cfg_t    regs
);

    wbs_pkg::cfg_t regs_reg;
    wbs_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // register decode
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                wbs_pkg::REG_LEARN_MODE:
                    regs_next.learn_mode = cfg.data[0];
                wbs_pkg::REG_WEIGHT_CURRENT:
                    regs_next.weight_current = cfg.data[wbs_pkg::WEIGHT_W-1:0];
                wbs_pkg::REG_WEIGHT_PREVIOUS:
                    regs_next.weight_previous = cfg.data[wbs_pkg::WEIGHT_W-1:0];
                wbs_pkg::REG_WEIGHT_OLDER:
                    regs_next.weight_older = cfg.data[wbs_pkg::WEIGHT_W-1:0];
                wbs_pkg::REG_MATCH_THRESHOLD:
                    regs_next.match_threshold = cfg.data[wbs_pkg::LUMA_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.learn_mode      <= 1'b0;
            regs_reg.weight_current  <= wbs_pkg::WEIGHT_CURRENT_RST;
            regs_reg.weight_previous <= wbs_pkg::WEIGHT_PREVIOUS_RST;
            regs_reg.weight_older    <= wbs_pkg::WEIGHT_OLDER_RST;
            regs_reg.match_threshold <= wbs_pkg::MATCH_THRESHOLD_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== rtl/core/wbs_history.sv =====
// per-lane luma history ram, one read and one write port, registered read
module wbs_history #(
    parameter int DEPTH  = 38400,
    parameter int ADDR_W = 16
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [wbs_pkg::HIST_W-1:0]  rd_data,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [wbs_pkg::HIST_W-1:0]  wr_data
);

    logic [wbs_pkg::HIST_W-1:0] hist_mem [DEPTH];
    logic [wbs_pkg::HIST_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/wbs_lane.sv =====
// one pixel lane: history update, weighted estimate and threshold compare, or luma passthrough in learn mode
module wbs_lane (
    input  logic                        clk,
    input  logic                        en,
    input  wbs_pkg::cfg_t               regs,
    input  logic                        in_frame,
    input  logic [wbs_pkg::LUMA_W-1:0]  luma,
    input  logic [wbs_pkg::HIST_W-1:0]  hist,
    output logic [wbs_pkg::HIST_W-1:0]  hist_new,
    output logic [wbs_pkg::LUMA_W-1:0]  pixel
);

    localparam int L = wbs_pkg::LUMA_W;

    logic [L-1:0]               prev;
    logic [L-1:0]               older;
    logic [wbs_pkg::PROD_W-1:0] prod_cur_reg;
    logic [wbs_pkg::PROD_W-1:0] prod_prev_reg;
    logic [wbs_pkg::PROD_W-1:0] prod_old_reg;
    logic [L-1:0]               luma_reg;
    logic                       learn_reg;
    logic [wbs_pkg::SUM_W-1:0]  sum;
    logic [L-1:0]               est;
    logic [L-1:0]               diff;

    // history lookup; pixels outside the frame see zero
    assign prev  = in_frame ? hist[L-1:0] : '0;
    assign older = in_frame ? hist[2*L-1:L] : '0;

    // history shifts by one frame, learn fills both bytes
    assign hist_new = regs.learn_mode ? {luma, luma} : {prev, luma};

    // product stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_cur_reg  <= regs.weight_current * luma;
            prod_prev_reg <= regs.weight_previous * prev;
            prod_old_reg  <= regs.weight_older * older;
            luma_reg      <= luma;
            learn_reg     <= regs.learn_mode;
        end
    end

    // sum, truncate to integer and saturate
    assign sum = wbs_pkg::SUM_W'(prod_cur_reg) + wbs_pkg::SUM_W'(prod_prev_reg)
               + wbs_pkg::SUM_W'(prod_old_reg);
    assign est = (|sum[wbs_pkg::SUM_W-1:wbs_pkg::WEIGHT_W+L]) ? wbs_pkg::LUMA_MAX
               : sum[wbs_pkg::WEIGHT_W+L-1:wbs_pkg::WEIGHT_W];

    // absolute difference against the threshold
    assign diff = (luma_reg > est) ? (luma_reg - est) : (est - luma_reg);

    always_comb
    begin
        if (learn_reg)
        begin
            pixel = luma_reg;
        end
        else if (diff < regs.match_threshold)
        begin
            pixel = wbs_pkg::MASK_BACKGROUND;
        end
        else
        begin
            pixel = wbs_pkg::MASK_FOREGROUND;
        end
    end

endmodule
